// ===== rtl/bst_pkg.sv =====
// bst_pkg: types, codes and per-byte scan functions of the source tokenizer
// depends on nothing; used by rtl/basic_source_tokenizer.sv, the checkers and the testbench
`default_nettype none

package bst_pkg;

  // result queue sizing
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int RCNT_W  = $clog2(MAX_RES + 1);

  // token kinds
  localparam logic [4:0] KIND_IDENT   = 5'd0;
  localparam logic [4:0] KIND_NUMBER  = 5'd1;
  localparam logic [4:0] KIND_STRING  = 5'd2;
  localparam logic [4:0] KIND_COMMENT = 5'd3;
  localparam logic [4:0] KIND_EOL     = 5'd4;
  localparam logic [4:0] KIND_NE      = 5'd5;
  localparam logic [4:0] KIND_LTE     = 5'd6;
  localparam logic [4:0] KIND_GTE     = 5'd7;
  localparam logic [4:0] KIND_ADD     = 5'd8;
  localparam logic [4:0] KIND_SUB     = 5'd9;
  localparam logic [4:0] KIND_MUL     = 5'd10;
  localparam logic [4:0] KIND_DIV     = 5'd11;
  localparam logic [4:0] KIND_COMMA   = 5'd12;
  localparam logic [4:0] KIND_LT      = 5'd13;
  localparam logic [4:0] KIND_GT      = 5'd14;
  localparam logic [4:0] KIND_EQ      = 5'd15;
  localparam logic [4:0] KIND_LPAREN  = 5'd16;
  localparam logic [4:0] KIND_RPAREN  = 5'd17;
  localparam logic [4:0] KIND_LBRACK  = 5'd18;
  localparam logic [4:0] KIND_RBRACK  = 5'd19;
  localparam logic [4:0] KIND_ERROR   = 5'd20;

  // error codes
  localparam logic [1:0] ERR_UNEXPECTED = 2'd0;
  localparam logic [1:0] ERR_NUMBER     = 2'd1;
  localparam logic [1:0] ERR_UNCLOSED   = 2'd2;
  localparam logic [1:0] ERR_ESCAPE     = 2'd3;
  localparam logic [1:0] ERR_NONE       = 2'd0;

  // characters with a role in the grammar
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_POINT  = 8'h2e;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_M      = 8'h4d;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_REM1    = 4'd1,
    MODE_REM2    = 4'd2,
    MODE_IDENT   = 4'd3,
    MODE_NUM     = 4'd4,
    MODE_STR     = 4'd5,
    MODE_COMMENT = 4'd6,
    MODE_LT      = 4'd7,
    MODE_GT      = 4'd8
  } scan_mode_e;

  // one result word without the run mark
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] ch;
    logic       first;
    logic       last;
    logic       no_char;
    logic [1:0] code;
  } res_t;

  // queued word
  typedef struct packed {
    res_t res;
    logic run_last;
  } qword_t;

  // scanner state
  typedef struct packed {
    scan_mode_e mode;
    logic [7:0] held0;
    logic [1:0] held_count;
    logic       point_seen;
    logic [1:0] escape_left;
    logic       token_open;
    logic       error_drop;
  } scan_t;

  // outcome of one scan step
  typedef struct packed {
    scan_t st;
    logic  emit;
    res_t  res;
    logic  done;
  } step_t;

  // outcome of the end of source
  typedef struct packed {
    scan_t      st;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } fin_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha_us(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7a)) || ((b >= 8'h41) && (b <= 8'h5a))
           || (b == CH_UNDER);
  endfunction

  // single-character symbol lookup, valid flag in the top bit
  function automatic logic [5:0] sym_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h3b:   k = {1'b1, KIND_EOL};
      8'h2b:   k = {1'b1, KIND_ADD};
      8'h2d:   k = {1'b1, KIND_SUB};
      8'h2a:   k = {1'b1, KIND_MUL};
      8'h2f:   k = {1'b1, KIND_DIV};
      8'h2c:   k = {1'b1, KIND_COMMA};
      8'h3d:   k = {1'b1, KIND_EQ};
      8'h28:   k = {1'b1, KIND_LPAREN};
      8'h29:   k = {1'b1, KIND_RPAREN};
      8'h5b:   k = {1'b1, KIND_LBRACK};
      8'h5d:   k = {1'b1, KIND_RBRACK};
      default: k = {1'b0, KIND_IDENT};
    endcase
    return k;
  endfunction

  function automatic res_t mk_res(input logic [4:0] kind, input logic [7:0] ch,
                                  input logic first, input logic last,
                                  input logic no_char, input logic [1:0] code);
    res_t r;
    r.kind    = kind;
    r.ch      = ch;
    r.first   = first;
    r.last    = last;
    r.no_char = no_char;
    r.code    = code;
    return r;
  endfunction

  function automatic scan_t to_idle(input scan_t s);
    scan_t t;
    t             = s;
    t.mode        = MODE_IDLE;
    t.held_count  = 2'd0;
    t.point_seen  = 1'b0;
    t.escape_left = 2'd0;
    t.token_open  = 1'b0;
    return t;
  endfunction

  // append a character: the one held before it goes out
  function automatic step_t push_step(input scan_t s, input logic [4:0] kind,
                                      input logic [7:0] c);
    step_t t;
    t.st   = s;
    t.emit = 1'b0;
    t.res  = '0;
    t.done = 1'b1;
    if (s.held_count != 2'd0) begin
      t.emit        = 1'b1;
      t.res         = mk_res(kind, s.held0, ~s.token_open, 1'b0, 1'b0, ERR_NONE);
      t.st.token_open = 1'b1;
    end
    t.st.held0      = c;
    t.st.held_count = 2'd1;
    return t;
  endfunction

  // close the open token with its held character, or as an empty token
  function automatic step_t close_step(input scan_t s, input logic [4:0] kind);
    step_t t;
    t.emit = 1'b1;
    t.done = 1'b1;
    if (s.held_count != 2'd0) begin
      t.res = mk_res(kind, s.held0, ~s.token_open, 1'b1, 1'b0, ERR_NONE);
    end else begin
      t.res = mk_res(kind, 8'h00, 1'b1, 1'b1, 1'b1, ERR_NONE);
    end
    t.st = to_idle(s);
    return t;
  endfunction

  function automatic step_t err_step(input scan_t s, input logic [1:0] code,
                                     input logic [7:0] ch, input logic has_char);
    step_t t;
    t.emit = 1'b1;
    t.done = 1'b1;
    t.res  = mk_res(KIND_ERROR, has_char ? ch : 8'h00, 1'b1, 1'b1, ~has_char, code);
    t.st   = to_idle(s);
    t.st.error_drop = 1'b1;
    return t;
  endfunction

  // one symbol emitted, back to idle
  function automatic step_t sym_step(input scan_t s, input logic [4:0] kind,
                                     input logic [7:0] ch, input logic done);
    step_t t;
    t.emit = 1'b1;
    t.done = done;
    t.res  = mk_res(kind, ch, 1'b1, 1'b1, 1'b0, ERR_NONE);
    t.st   = to_idle(s);
    return t;
  endfunction

  // a byte seen between tokens
  function automatic step_t idle_step(input scan_t s, input logic [7:0] b);
    step_t      t;
    logic [5:0] k;
    t.st   = s;
    t.emit = 1'b0;
    t.res  = '0;
    t.done = 1'b1;
    k      = sym_kind(b);
    if (is_space(b)) begin
      t.done = 1'b1;
    end else if (b == CH_R) begin
      t.st.held0      = CH_R;
      t.st.held_count = 2'd1;
      t.st.mode       = MODE_REM1;
    end else if (is_alpha_us(b)) begin
      t.st.mode       = MODE_IDENT;
      t.st.token_open = 1'b0;
      t.st.held0      = b;
      t.st.held_count = 2'd1;
    end else if (is_digit(b) || (b == CH_POINT)) begin
      t.st.mode       = MODE_NUM;
      t.st.token_open = 1'b0;
      t.st.held0      = b;
      t.st.held_count = 2'd1;
      t.st.point_seen = (b == CH_POINT);
    end else if (b == CH_QUOTE) begin
      t.st.mode        = MODE_STR;
      t.st.token_open  = 1'b0;
      t.st.held_count  = 2'd0;
      t.st.escape_left = 2'd0;
    end else if (b == CH_LT) begin
      t.st.mode = MODE_LT;
    end else if (b == CH_GT) begin
      t.st.mode = MODE_GT;
    end else if (k[5]) begin
      t.emit = 1'b1;
      t.res  = mk_res(k[4:0], b, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else begin
      t = err_step(s, ERR_UNEXPECTED, b, 1'b1);
    end
    return t;
  endfunction

  // one scan step; done low means the byte must be seen again
  function automatic step_t handle(input scan_t s, input logic [7:0] b);
    step_t t;
    scan_t s2;
    t.st   = s;
    t.emit = 1'b0;
    t.res  = '0;
    t.done = 1'b1;
    s2     = s;
    case (s.mode)
      MODE_IDLE: begin
        t = idle_step(s, b);
      end
      MODE_REM1: begin
        if (b == CH_E) begin
          t.st.held_count = 2'd2;
          t.st.mode       = MODE_REM2;
        end else begin
          t.st.mode       = MODE_IDENT;
          t.st.held_count = 2'd1;
          t.st.token_open = 1'b0;
          t.done          = 1'b0;
        end
      end
      MODE_REM2: begin
        if (b == CH_M) begin
          t.st.mode       = MODE_COMMENT;
          t.st.held_count = 2'd0;
          t.st.token_open = 1'b0;
        end else begin
          t.emit          = 1'b1;
          t.res           = mk_res(KIND_IDENT, CH_R, 1'b1, 1'b0, 1'b0, ERR_NONE);
          t.st.held0      = CH_E;
          t.st.held_count = 2'd1;
          t.st.token_open = 1'b1;
          t.st.mode       = MODE_IDENT;
          t.done          = 1'b0;
        end
      end
      MODE_IDENT: begin
        if (is_alpha_us(b) || is_digit(b)) begin
          t = push_step(s, KIND_IDENT, b);
        end else begin
          t      = close_step(s, KIND_IDENT);
          t.done = 1'b0;
        end
      end
      MODE_NUM: begin
        if (is_digit(b) || (b == CH_POINT)) begin
          if ((b == CH_POINT) && s.point_seen) begin
            t = err_step(s, ERR_NUMBER, b, 1'b1);
          end else begin
            if (b == CH_POINT) begin
              s2.point_seen = 1'b1;
            end
            t = push_step(s2, KIND_NUMBER, b);
          end
        end else begin
          t      = close_step(s, KIND_NUMBER);
          t.done = 1'b0;
        end
      end
      MODE_STR: begin
        if (s.escape_left != 2'd0) begin
          t = push_step(s, KIND_STRING, b);
          t.st.escape_left = s.escape_left - 2'd1;
        end else if (b == CH_BSLASH) begin
          t = push_step(s, KIND_STRING, b);
          t.st.escape_left = 2'd2;
        end else if (b == CH_QUOTE) begin
          t = close_step(s, KIND_STRING);
        end else begin
          t = push_step(s, KIND_STRING, b);
        end
      end
      MODE_COMMENT: begin
        if (b == CH_LF) begin
          t = close_step(s, KIND_COMMENT);
        end else begin
          t = push_step(s, KIND_COMMENT, b);
        end
      end
      MODE_LT: begin
        if (b == CH_GT) begin
          t = sym_step(s, KIND_NE, CH_LT, 1'b1);
        end else if (b == CH_EQ) begin
          t = sym_step(s, KIND_LTE, CH_LT, 1'b1);
        end else begin
          t = sym_step(s, KIND_LT, CH_LT, 1'b0);
        end
      end
      MODE_GT: begin
        if (b == CH_EQ) begin
          t = sym_step(s, KIND_GTE, CH_GT, 1'b1);
        end else begin
          t = sym_step(s, KIND_GT, CH_GT, 1'b0);
        end
      end
      default: begin
        t.st   = to_idle(s);
        t.done = 1'b0;
      end
    endcase
    return t;
  endfunction

  // close whatever is open at the end of the source
  function automatic fin_t finish(input scan_t s);
    fin_t  f;
    step_t t;
    f.st = to_idle(s);
    f.st.error_drop = 1'b0;
    f.n  = 2'd0;
    f.r0 = '0;
    f.r1 = '0;
    case (s.mode)
      MODE_REM1: begin
        f.n  = 2'd1;
        f.r0 = mk_res(KIND_IDENT, CH_R, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      MODE_REM2: begin
        f.n  = 2'd2;
        f.r0 = mk_res(KIND_IDENT, CH_R, 1'b1, 1'b0, 1'b0, ERR_NONE);
        f.r1 = mk_res(KIND_IDENT, CH_E, 1'b0, 1'b1, 1'b0, ERR_NONE);
      end
      MODE_IDENT: begin
        t    = close_step(s, KIND_IDENT);
        f.n  = 2'd1;
        f.r0 = t.res;
      end
      MODE_NUM: begin
        t    = close_step(s, KIND_NUMBER);
        f.n  = 2'd1;
        f.r0 = t.res;
      end
      MODE_COMMENT: begin
        t    = close_step(s, KIND_COMMENT);
        f.n  = 2'd1;
        f.r0 = t.res;
      end
      MODE_STR: begin
        f.n  = 2'd1;
        f.r0 = mk_res(KIND_ERROR, 8'h00, 1'b1, 1'b1, 1'b1,
                      (s.escape_left != 2'd0) ? ERR_ESCAPE : ERR_UNCLOSED);
      end
      MODE_LT: begin
        f.n  = 2'd1;
        f.r0 = mk_res(KIND_LT, CH_LT, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      MODE_GT: begin
        f.n  = 2'd1;
        f.r0 = mk_res(KIND_GT, CH_GT, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end
      default: begin
        f.n = 2'd0;
      end
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/basic_source_tokenizer.sv =====
// basic_source_tokenizer: streaming lexer for a small BASIC dialect
// depends on rtl/bst_pkg.sv for types, codes and scan functions
`default_nettype none

// The block takes one source byte per cycle while in_ready_o is high and
// turns it into zero to three result words (token characters tagged with kind
// and first/last marks), which go into a four-entry result queue. A byte is
// taken whenever at most one word is queued, so with one word per byte and
// out_ready_i high the input never stalls; a byte that yields two or three
// words (a broken "RE" prefix, an operator closing an identifier, the end of
// source) holds the input while the queue drains at one word per cycle as the
// output side accepts words. Scan state and the queued words are registered
// in the same cycle the byte is taken. After an error, bytes are taken while
// at most one word is queued and dropped until the end-of-source byte.
module basic_source_tokenizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] source_byte_i,
  input  wire logic       source_end_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [4:0]      token_kind_o,
  output logic [7:0]      token_char_o,
  output logic            token_first_o,
  output logic            token_last_o,
  output logic            no_char_o,
  output logic [1:0]      error_code_o,
  output logic            run_last_o
);

  bst_pkg::scan_t  scan_q, scan_d;
  bst_pkg::res_t   res [bst_pkg::MAX_RES];
  logic [bst_pkg::RCNT_W-1:0] res_n;

  bst_pkg::qword_t queue_q [bst_pkg::QDEPTH];
  logic [bst_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [bst_pkg::QCNT_W-1:0] count_q;

  logic in_fire, out_fire;

  assign in_ready_o  = count_q <= bst_pkg::QCNT_W'(bst_pkg::QDEPTH - bst_pkg::MAX_RES);
  assign out_valid_o = count_q != '0;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  // scan the byte: up to three scan passes, then the end-of-source close
  always_comb begin
    bst_pkg::scan_t s;
    bst_pkg::step_t t;
    bst_pkg::fin_t  f;
    logic           done;
    s     = scan_q;
    t     = '0;
    f     = '0;
    done  = 1'b0;
    res_n = '0;
    for (int j = 0; j < bst_pkg::MAX_RES; j++) begin
      res[j] = '0;
    end
    if (scan_q.error_drop) begin
      if (source_end_i) begin
        s = bst_pkg::to_idle(scan_q);
        s.error_drop = 1'b0;
      end
    end else begin
      for (int i = 0; i < bst_pkg::MAX_RES; i++) begin
        if (!done) begin
          t    = bst_pkg::handle(s, source_byte_i);
          s    = t.st;
          done = t.done;
          if (t.emit && (res_n < bst_pkg::RCNT_W'(bst_pkg::MAX_RES))) begin
            res[res_n[bst_pkg::QPTR_W-1:0]] = t.res;
            res_n = res_n + 1'b1;
          end
        end
      end
      if (source_end_i) begin
        f = bst_pkg::finish(s);
        s = f.st;
        if ((f.n != 2'd0) && (res_n < bst_pkg::RCNT_W'(bst_pkg::MAX_RES))) begin
          res[res_n[bst_pkg::QPTR_W-1:0]] = f.r0;
          res_n = res_n + 1'b1;
        end
        if ((f.n == 2'd2) && (res_n < bst_pkg::RCNT_W'(bst_pkg::MAX_RES))) begin
          res[res_n[bst_pkg::QPTR_W-1:0]] = f.r1;
          res_n = res_n + 1'b1;
        end
      end
    end
    scan_d = s;
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= bst_pkg::to_idle('0);
    end else if (in_fire) begin
      scan_q <= scan_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int j = 0; j < bst_pkg::MAX_RES; j++) begin
        if (bst_pkg::RCNT_W'(j) < res_n) begin
          queue_q[wr_ptr_q + bst_pkg::QPTR_W'(j)] <=
            '{res: res[j], run_last: (bst_pkg::RCNT_W'(j + 1) == res_n)};
        end
      end
    end
  end

  // result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + res_n[bst_pkg::QPTR_W-1:0];
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (in_fire ? bst_pkg::QCNT_W'(res_n) : '0)
                 - bst_pkg::QCNT_W'(out_fire);
    end
  end

  // head word to the ports
  assign token_kind_o  = queue_q[rd_ptr_q].res.kind;
  assign token_char_o  = queue_q[rd_ptr_q].res.ch;
  assign token_first_o = queue_q[rd_ptr_q].res.first;
  assign token_last_o  = queue_q[rd_ptr_q].res.last;
  assign no_char_o     = queue_q[rd_ptr_q].res.no_char;
  assign error_code_o  = queue_q[rd_ptr_q].res.code;
  assign run_last_o    = queue_q[rd_ptr_q].run_last;

endmodule

`default_nettype wire

// ===== rtl/bst_checker.sv =====
// bst_checker: port-level assertions on the tokenizer output words
// depends on rtl/bst_pkg.sv; bound to basic_source_tokenizer below
`default_nettype none

module bst_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [4:0] token_kind_o,
  input wire logic [7:0] token_char_o,
  input wire logic       token_first_o,
  input wire logic       token_last_o,
  input wire logic       no_char_o,
  input wire logic [1:0] error_code_o,
  input wire logic       run_last_o
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_kind_o)
      && $stable(token_char_o) && $stable(run_last_o))
    else $error("stalled output word changed");

  // an error word is a whole token with first and last marks
  a_err_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == bst_pkg::KIND_ERROR)
      |-> token_first_o && token_last_o)
    else $error("error word without first/last marks");

  // an unused character reads as zero and its word is a whole token
  a_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_char_o |-> (token_char_o == 8'h00) && token_first_o && token_last_o)
    else $error("empty token word malformed");

  // error code only on error words; other kinds lie below the error kind
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o != bst_pkg::KIND_ERROR)
      |-> (error_code_o == bst_pkg::ERR_NONE) && (token_kind_o < bst_pkg::KIND_ERROR))
    else $error("error code on a plain token word");

endmodule

bind basic_source_tokenizer bst_checker u_bst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .token_kind_o  (token_kind_o),
  .token_char_o  (token_char_o),
  .token_first_o (token_first_o),
  .token_last_o  (token_last_o),
  .no_char_o     (no_char_o),
  .error_code_o  (error_code_o),
  .run_last_o    (run_last_o)
);

`default_nettype wire

// ===== dv/token_stream_checker.sv =====
// token_stream_checker: watches both channels of the source tokenizer, predicts
// the token words of every accepted source byte and compares them in order
// depends on rtl/bst_pkg.sv for token kinds, error codes, characters and modes
module token_stream_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] source_byte_i,
  input  wire logic       source_end_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [4:0] token_kind_i,
  input  wire logic [7:0] token_char_i,
  input  wire logic       token_first_i,
  input  wire logic       token_last_i,
  input  wire logic       no_char_i,
  input  wire logic [1:0] error_code_i,
  input  wire logic       run_last_i,
  output int              mismatch_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] ch;
    logic       first;
    logic       last;
    logic       no_char;
    logic [1:0] code;
    logic       run_last;
  } token_word_t;

  // lexer state of the prediction
  bst_pkg::scan_mode_e lex_mode;
  logic [7:0]  held_ch;
  logic [1:0]  held_n;
  logic        point_seen;
  logic [1:0]  esc_left;
  logic        tok_open;
  logic        dropping;

  token_word_t byte_words[$];
  token_word_t expected_words[$];
  int          bad_words;

  // character classes
  function automatic bit is_blank(input logic [7:0] b);
    return (b == bst_pkg::CH_SPACE) || ((b >= bst_pkg::CH_TAB) && (b <= bst_pkg::CH_CR));
  endfunction

  function automatic bit is_digit_ch(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic bit is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
           || (b == bst_pkg::CH_UNDER);
  endfunction

  // one-character symbols that stand alone
  function automatic bit single_symbol(input logic [7:0] b, output logic [4:0] k);
    bit found;
    found = 1'b1;
    k     = bst_pkg::KIND_IDENT;
    case (b)
      ";":     k = bst_pkg::KIND_EOL;
      "+":     k = bst_pkg::KIND_ADD;
      "-":     k = bst_pkg::KIND_SUB;
      "*":     k = bst_pkg::KIND_MUL;
      "/":     k = bst_pkg::KIND_DIV;
      ",":     k = bst_pkg::KIND_COMMA;
      "=":     k = bst_pkg::KIND_EQ;
      "(":     k = bst_pkg::KIND_LPAREN;
      ")":     k = bst_pkg::KIND_RPAREN;
      "[":     k = bst_pkg::KIND_LBRACK;
      "]":     k = bst_pkg::KIND_RBRACK;
      default: found = 1'b0;
    endcase
    return found;
  endfunction

  task automatic add_word(input logic [4:0] kind, input logic [7:0] ch, input logic first,
                          input logic last, input logic no_char, input logic [1:0] code);
    token_word_t w;
    w.kind     = kind;
    w.ch       = ch;
    w.first    = first;
    w.last     = last;
    w.no_char  = no_char;
    w.code     = code;
    w.run_last = 1'b0;
    if (byte_words.size() < bst_pkg::MAX_RES) byte_words = {byte_words, w};
  endtask

  task automatic go_idle();
    lex_mode   = bst_pkg::MODE_IDLE;
    held_n     = 2'd0;
    point_seen = 1'b0;
    esc_left   = 2'd0;
    tok_open   = 1'b0;
  endtask

  // the held character goes out, the new one is held
  task automatic append_char(input logic [4:0] kind, input logic [7:0] c);
    if (held_n != 2'd0) begin
      add_word(kind, held_ch, ~tok_open, 1'b0, 1'b0, bst_pkg::ERR_NONE);
      tok_open = 1'b1;
    end
    held_ch = c;
    held_n  = 2'd1;
  endtask

  task automatic close_token(input logic [4:0] kind);
    if (held_n != 2'd0) add_word(kind, held_ch, ~tok_open, 1'b1, 1'b0, bst_pkg::ERR_NONE);
    else add_word(kind, 8'h00, 1'b1, 1'b1, 1'b1, bst_pkg::ERR_NONE);
    go_idle();
  endtask

  task automatic raise_error(input logic [1:0] code, input logic [7:0] ch, input bit has_ch);
    add_word(bst_pkg::KIND_ERROR, has_ch ? ch : 8'h00, 1'b1, 1'b1, ~has_ch, code);
    go_idle();
    dropping = 1'b1;
  endtask

  task automatic start_token(input logic [7:0] b);
    logic [4:0] k;
    if (is_blank(b)) begin
      // skipped between tokens
    end else if (b == bst_pkg::CH_R) begin
      held_ch  = bst_pkg::CH_R;
      held_n   = 2'd1;
      lex_mode = bst_pkg::MODE_REM1;
    end else if (is_letter(b)) begin
      lex_mode = bst_pkg::MODE_IDENT;
      tok_open = 1'b0;
      held_ch  = b;
      held_n   = 2'd1;
    end else if (is_digit_ch(b) || (b == bst_pkg::CH_POINT)) begin
      lex_mode   = bst_pkg::MODE_NUM;
      tok_open   = 1'b0;
      held_ch    = b;
      held_n     = 2'd1;
      point_seen = (b == bst_pkg::CH_POINT);
    end else if (b == bst_pkg::CH_QUOTE) begin
      lex_mode = bst_pkg::MODE_STR;
      tok_open = 1'b0;
      held_n   = 2'd0;
      esc_left = 2'd0;
    end else if (b == bst_pkg::CH_LT) begin
      lex_mode = bst_pkg::MODE_LT;
    end else if (b == bst_pkg::CH_GT) begin
      lex_mode = bst_pkg::MODE_GT;
    end else if (single_symbol(b, k)) begin
      add_word(k, b, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
    end else begin
      raise_error(bst_pkg::ERR_UNEXPECTED, b, 1'b1);
    end
  endtask

  // one pass over the byte; taken low means the byte is scanned again
  task automatic scan_once(input logic [7:0] b, output bit taken);
    taken = 1'b1;
    case (lex_mode)
      bst_pkg::MODE_IDLE: start_token(b);
      bst_pkg::MODE_REM1: begin
        if (b == bst_pkg::CH_E) begin
          held_n   = 2'd2;
          lex_mode = bst_pkg::MODE_REM2;
        end else begin
          lex_mode = bst_pkg::MODE_IDENT;
          held_n   = 2'd1;
          tok_open = 1'b0;
          taken    = 1'b0;
        end
      end
      bst_pkg::MODE_REM2: begin
        if (b == bst_pkg::CH_M) begin
          lex_mode = bst_pkg::MODE_COMMENT;
          held_n   = 2'd0;
          tok_open = 1'b0;
        end else begin
          // broken prefix: R goes out, E stays held as an identifier
          add_word(bst_pkg::KIND_IDENT, bst_pkg::CH_R, 1'b1, 1'b0, 1'b0, bst_pkg::ERR_NONE);
          held_ch  = bst_pkg::CH_E;
          held_n   = 2'd1;
          tok_open = 1'b1;
          lex_mode = bst_pkg::MODE_IDENT;
          taken    = 1'b0;
        end
      end
      bst_pkg::MODE_IDENT: begin
        if (is_letter(b) || is_digit_ch(b)) begin
          append_char(bst_pkg::KIND_IDENT, b);
        end else begin
          close_token(bst_pkg::KIND_IDENT);
          taken = 1'b0;
        end
      end
      bst_pkg::MODE_NUM: begin
        if (is_digit_ch(b) || (b == bst_pkg::CH_POINT)) begin
          if ((b == bst_pkg::CH_POINT) && point_seen) begin
            raise_error(bst_pkg::ERR_NUMBER, b, 1'b1);
          end else begin
            if (b == bst_pkg::CH_POINT) point_seen = 1'b1;
            append_char(bst_pkg::KIND_NUMBER, b);
          end
        end else begin
          close_token(bst_pkg::KIND_NUMBER);
          taken = 1'b0;
        end
      end
      bst_pkg::MODE_STR: begin
        if (esc_left != 2'd0) begin
          append_char(bst_pkg::KIND_STRING, b);
          esc_left = esc_left - 2'd1;
        end else if (b == bst_pkg::CH_BSLASH) begin
          append_char(bst_pkg::KIND_STRING, b);
          esc_left = 2'd2;
        end else if (b == bst_pkg::CH_QUOTE) begin
          close_token(bst_pkg::KIND_STRING);
        end else begin
          append_char(bst_pkg::KIND_STRING, b);
        end
      end
      bst_pkg::MODE_COMMENT: begin
        if (b == bst_pkg::CH_LF) close_token(bst_pkg::KIND_COMMENT);
        else append_char(bst_pkg::KIND_COMMENT, b);
      end
      bst_pkg::MODE_LT: begin
        if (b == bst_pkg::CH_GT) begin
          add_word(bst_pkg::KIND_NE, bst_pkg::CH_LT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
        end else if (b == bst_pkg::CH_EQ) begin
          add_word(bst_pkg::KIND_LTE, bst_pkg::CH_LT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
        end else begin
          add_word(bst_pkg::KIND_LT, bst_pkg::CH_LT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
          taken = 1'b0;
        end
        go_idle();
      end
      bst_pkg::MODE_GT: begin
        if (b == bst_pkg::CH_EQ) begin
          add_word(bst_pkg::KIND_GTE, bst_pkg::CH_GT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
        end else begin
          add_word(bst_pkg::KIND_GT, bst_pkg::CH_GT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
          taken = 1'b0;
        end
        go_idle();
      end
      default: begin
        go_idle();
        taken = 1'b0;
      end
    endcase
  endtask

  // end of source closes what is open
  task automatic end_of_source();
    case (lex_mode)
      bst_pkg::MODE_REM1:
        add_word(bst_pkg::KIND_IDENT, bst_pkg::CH_R, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
      bst_pkg::MODE_REM2: begin
        add_word(bst_pkg::KIND_IDENT, bst_pkg::CH_R, 1'b1, 1'b0, 1'b0, bst_pkg::ERR_NONE);
        add_word(bst_pkg::KIND_IDENT, bst_pkg::CH_E, 1'b0, 1'b1, 1'b0, bst_pkg::ERR_NONE);
      end
      bst_pkg::MODE_IDENT:   close_token(bst_pkg::KIND_IDENT);
      bst_pkg::MODE_NUM:     close_token(bst_pkg::KIND_NUMBER);
      bst_pkg::MODE_COMMENT: close_token(bst_pkg::KIND_COMMENT);
      bst_pkg::MODE_STR:
        raise_error((esc_left != 2'd0) ? bst_pkg::ERR_ESCAPE : bst_pkg::ERR_UNCLOSED,
                    8'h00, 1'b0);
      bst_pkg::MODE_LT:
        add_word(bst_pkg::KIND_LT, bst_pkg::CH_LT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
      bst_pkg::MODE_GT:
        add_word(bst_pkg::KIND_GT, bst_pkg::CH_GT, 1'b1, 1'b1, 1'b0, bst_pkg::ERR_NONE);
      default:      ;
    endcase
    go_idle();
    dropping = 1'b0;
  endtask

  // words caused by one accepted source byte
  task automatic lex_byte(input logic [7:0] b, input logic is_end);
    bit taken;
    byte_words.delete();
    if (dropping) begin
      if (is_end) begin
        go_idle();
        dropping = 1'b0;
      end
    end else begin
      taken = 1'b0;
      for (int pass = 0; (pass < 4) && !taken; pass++) scan_once(b, taken);
      if (is_end) end_of_source();
    end
    if (byte_words.size() > 0) byte_words[byte_words.size() - 1].run_last = 1'b1;
    foreach (byte_words[n]) expected_words = {expected_words, byte_words[n]};
  endtask

  function automatic int field_differs(input string name, input int want, input int got);
    if (want == got) return 0;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return 1;
  endfunction

  task automatic compare_word();
    token_word_t want;
    int          diffs;
    if (expected_words.size() == 0) begin
      $display("%0t: word with nothing expected, kind %0d char %0d", $time, token_kind_i,
               token_char_i);
      bad_words++;
    end else begin
      want  = expected_words.pop_front();
      diffs = 0;
      diffs += field_differs("token_kind", want.kind, token_kind_i);
      diffs += field_differs("token_char", want.ch, token_char_i);
      diffs += field_differs("token_first", want.first, token_first_i);
      diffs += field_differs("token_last", want.last, token_last_i);
      diffs += field_differs("no_char", want.no_char, no_char_i);
      diffs += field_differs("error_code", want.code, error_code_i);
      diffs += field_differs("run_last", want.run_last, run_last_i);
      if (diffs != 0) bad_words++;
    end
  endtask

  // bytes are predicted before words are compared in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_idle();
      held_ch  = 8'h00;
      dropping = 1'b0;
      expected_words.delete();
      bad_words = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (in_valid_i && in_ready_i) lex_byte(source_byte_i, source_end_i);
      if (out_valid_i && out_ready_i) compare_word();
      mismatch_count_o <= bad_words;
      pending_o        <= expected_words.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench: drives source text into basic_source_tokenizer with random gaps and
// output stalls, and gives the verdict from the mismatch and pending counts of the token_stream_checker
// depends on rtl/bst_pkg.sv, rtl/basic_source_tokenizer.sv, dv/token_stream_checker.sv
module testbench;

  localparam int LIMIT_CYCLES    = 300000;
  localparam int PRESSURE_CYCLES = 200;
  localparam int RANDOM_BYTES    = 115;
  localparam int DRAIN_CYCLES    = 20;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] source_byte   = 8'h00;
  logic       source_end    = 1'b0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic [4:0] token_kind;
  logic [7:0] token_char;
  logic       token_first;
  logic       token_last;
  logic       no_char;
  logic [1:0] error_code;
  logic       run_last;

  int         mismatches;
  int         pending;
  int         cycle_count   = 0;
  int         hold_left     = 0;
  bit         hold_done     = 1'b0;
  bit         hold_req      = 1'b0;
  bit         calm          = 1'b0;
  logic [7:0] src_bytes[$];

  basic_source_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .source_byte_i (source_byte),
    .source_end_i  (source_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .token_kind_o  (token_kind),
    .token_char_o  (token_char),
    .token_first_o (token_first),
    .token_last_o  (token_last),
    .no_char_o     (no_char),
    .error_code_o  (error_code),
    .run_last_o    (run_last)
  );

  token_stream_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .source_byte_i    (source_byte),
    .source_end_i     (source_end),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .token_kind_i     (token_kind),
    .token_char_i     (token_char),
    .token_first_i    (token_first),
    .token_last_i     (token_last),
    .no_char_i        (no_char),
    .error_code_i     (error_code),
    .run_last_i       (run_last),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= PRESSURE_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (!calm && ($urandom_range(0, 99) < 20)) begin
      out_ready <= 1'b0;
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || (r < 55)) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // one byte offered after an optional gap, held until accepted
  task automatic send_byte(input logic [7:0] b, input logic is_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    source_byte <= b;
    source_end  <= is_end;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  // the queued source goes out with the end mark on its last byte
  task automatic send_source();
    foreach (src_bytes[n]) send_byte(src_bytes[n], n == src_bytes.size() - 1);
    src_bytes.delete();
  endtask

  // append one byte to the queued source
  task automatic put_byte(input logic [7:0] b);
    src_bytes = {src_bytes, b};
  endtask

  task automatic add_text(input string s);
    for (int n = 0; n < s.len(); n++) put_byte(s[n]);
  endtask

  function automatic logic [7:0] rand_letter();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 52);
    if (r < 26) begin
      c = "a";
      c = c + r[7:0];
    end else if (r < 52) begin
      c = "A";
      c = c + r[7:0] - 8'd26;
    end else begin
      c = bst_pkg::CH_UNDER;
    end
    return c;
  endfunction

  function automatic logic [7:0] rand_digit();
    logic [7:0] c;
    c = "0";
    return c + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_printable();
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic string operator_text(input int idx);
    case (idx)
      0:       return "<>";
      1:       return "<=";
      2:       return ">=";
      3:       return "<";
      4:       return ">";
      5:       return ";";
      6:       return "+";
      7:       return "-";
      8:       return "*";
      9:       return "/";
      10:      return ",";
      11:      return "=";
      12:      return "(";
      13:      return ")";
      14:      return "[";
      default: return "]";
    endcase
  endfunction

  task automatic add_blank();
    case ($urandom_range(0, 5))
      0:       put_byte(bst_pkg::CH_SPACE);
      1:       put_byte(bst_pkg::CH_TAB);
      2:       put_byte(bst_pkg::CH_LF);
      3:       put_byte(8'h0b);
      4:       put_byte(8'h0c);
      default: put_byte(bst_pkg::CH_CR);
    endcase
  endtask

  // mostly well-formed tokens, some broken ones and some noise
  task automatic add_random_token();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      put_byte(rand_letter());
      len = $urandom_range(0, 5);
      repeat (len) put_byte(($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter());
    end else if (r < 35) begin
      if ($urandom_range(0, 4) == 0) put_byte(bst_pkg::CH_POINT);
      len = $urandom_range(1, 4);
      repeat (len) put_byte(rand_digit());
      if ($urandom_range(0, 2) == 0) begin
        put_byte(bst_pkg::CH_POINT);
        len = $urandom_range(0, 3);
        repeat (len) put_byte(rand_digit());
      end
      if ($urandom_range(0, 9) == 0) put_byte(bst_pkg::CH_POINT);
    end else if (r < 50) begin
      put_byte(bst_pkg::CH_QUOTE);
      len = $urandom_range(0, 6);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          put_byte(bst_pkg::CH_BSLASH);
          put_byte(8'($urandom_range(0, 255)));
          put_byte(8'($urandom_range(0, 255)));
        end else if (r < 25) begin
          put_byte(8'($urandom_range(0, 255)));
        end else begin
          put_byte(rand_printable());
        end
      end
      if ($urandom_range(0, 9) != 0) put_byte(bst_pkg::CH_QUOTE);
    end else if (r < 60) begin
      add_text("REM");
      len = $urandom_range(0, 6);
      repeat (len) put_byte(rand_printable());
      if ($urandom_range(0, 9) != 0) put_byte(bst_pkg::CH_LF);
    end else if (r < 78) begin
      add_text(operator_text($urandom_range(0, 15)));
    end else if (r < 85) begin
      add_text(($urandom_range(0, 1) == 0) ? "R" : "RE");
    end else if (r < 92) begin
      add_blank();
    end else begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int random_sent;
    int tokens;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: broken REM prefix with three words from one byte
    add_text("RE+");
    send_source();
    // empty string, short prefix, operators, open '>' closed by end of source
    add_text("\"\"RX<=>");
    send_source();
    // malformed number, then bytes dropped up to the end mark
    add_text("1.2.");
    put_byte(8'hff);
    send_source();
    // empty comment at end of source
    add_text("REM");
    send_source();
    // end of source inside an escape
    add_text("\"\\a");
    send_source();
    // unexpected byte that is also the end of source
    put_byte(8'h00);
    send_source();
    // unclosed string
    add_text("\"x");
    send_source();
    // held R and RE at end of source
    add_text("R");
    send_source();
    add_text("RE");
    send_source();

    // random sources; the first one runs into a long receiver hold-off
    hold_req    <= 1'b1;
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      tokens = $urandom_range(1, 8);
      repeat (tokens) begin
        add_random_token();
        if ($urandom_range(0, 1) == 0) add_blank();
      end
      random_sent += src_bytes.size();
      calm <= ($urandom_range(0, 4) == 0);
      send_source();
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    // drain and verdict
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
